/* src/cte_pkg.sv */
// Shared types and register codes for the capture timestamp extender.
package cte_pkg;

   // Configuration register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_INTERVAL_STEP       = 2'd0;
   localparam logic [1:0] REG_POLL_STEP           = 2'd1;
   localparam logic [1:0] REG_INTERVALS_PER_FRAME = 2'd2;

   localparam logic [15:0] INTERVAL_STEP_RESET       = 16'd43750;
   localparam logic [15:0] POLL_STEP_RESET           = 16'd42000;
   localparam logic [7:0]  INTERVALS_PER_FRAME_RESET = 8'd30;

   typedef struct packed {
      logic        overflow_flag;
      logic        capture_a_flag;
      logic        capture_b_flag;
      logic        interval_flag;
      logic        poll_flag;
      logic [15:0] capture_a_value;
      logic [15:0] capture_b_value;
      logic [31:0] encoder_count_a;
      logic [31:0] encoder_count_b;
   } req_type;

   typedef struct packed {
      logic [63:0] time_a;
      logic [31:0] position_a;
      logic [31:0] captures_a;
      logic [63:0] time_b;
      logic [31:0] position_b;
      logic [31:0] captures_b;
      logic [31:0] frame_count;
      logic [31:0] poll_count;
      logic        frame_end;
      logic [15:0] next_interval_compare;
      logic [15:0] next_poll_compare;
   } rsp_type;

   typedef struct packed {
      logic [63:0] time_a;
      logic [31:0] position_a;
      logic [31:0] captures_a;
      logic [63:0] time_b;
      logic [31:0] position_b;
      logic [31:0] captures_b;
      logic [31:0] frame_ticks;
      logic [31:0] poll_ticks;
      logic [7:0]  interval_count;
      logic [15:0] interval_compare;
      logic [15:0] poll_compare;
   } state_type;

   typedef struct packed {
      logic [15:0] interval_step;
      logic [15:0] poll_step;
      logic [7:0]  intervals_per_frame;
   } cfg_type;

endpackage

/* src/cte_event_logic.sv */
// Next-state and result logic for one timer event snapshot.
module cte_event_logic #(
   parameter int COUNTER_WIDTH = 16
) (
   input  cte_pkg::req_type             req,
   input  cte_pkg::state_type           state,
   input  logic [63-COUNTER_WIDTH:0]    ext,
   input  cte_pkg::cfg_type             cfg,
   output cte_pkg::state_type           state_next,
   output logic [63-COUNTER_WIDTH:0]    ext_next,
   output cte_pkg::rsp_type             rsp
);

   localparam int EXT_W = 64 - COUNTER_WIDTH;

   logic [COUNTER_WIDTH-1:0] low_a;
   logic [COUNTER_WIDTH-1:0] low_b;
   logic [EXT_W-1:0]         ext_a;
   logic [EXT_W-1:0]         ext_b;
   logic [7:0]               ivl_count_inc;
   logic                     frame_done;

   always_comb begin
      ext_next = req.overflow_flag ? ext + EXT_W'(1) : ext;

      low_a = COUNTER_WIDTH'(req.capture_a_value);
      low_b = COUNTER_WIDTH'(req.capture_b_value);

      // upper-half value with a wrap in the same event was captured before the wrap
      ext_a = (req.overflow_flag && low_a[COUNTER_WIDTH-1]) ? ext : ext_next;
      ext_b = (req.overflow_flag && low_b[COUNTER_WIDTH-1]) ? ext : ext_next;

      ivl_count_inc = state.interval_count + 8'd1;
      frame_done    = req.interval_flag && (ivl_count_inc >= cfg.intervals_per_frame);

      state_next = state;

      if (req.poll_flag) begin
         state_next.poll_compare = state.poll_compare + cfg.poll_step;
         state_next.poll_ticks   = state.poll_ticks + 32'd1;
      end

      if (req.capture_a_flag) begin
         state_next.time_a     = {ext_a, low_a};
         state_next.position_a = req.encoder_count_a;
         state_next.captures_a = state.captures_a + 32'd1;
      end

      if (req.capture_b_flag) begin
         state_next.time_b     = {ext_b, low_b};
         state_next.position_b = req.encoder_count_b;
         state_next.captures_b = state.captures_b + 32'd1;
      end

      if (req.interval_flag) begin
         state_next.interval_compare = state.interval_compare + cfg.interval_step;
         state_next.interval_count   = frame_done ? 8'd0 : ivl_count_inc;
         if (frame_done) begin
            state_next.frame_ticks = state.frame_ticks + 32'd1;
         end
      end

      rsp.time_a                = state_next.time_a;
      rsp.position_a            = state_next.position_a;
      rsp.captures_a            = state_next.captures_a;
      rsp.time_b                = state_next.time_b;
      rsp.position_b            = state_next.position_b;
      rsp.captures_b            = state_next.captures_b;
      rsp.frame_count           = state_next.frame_ticks;
      rsp.poll_count            = state_next.poll_ticks;
      rsp.frame_end             = frame_done;
      rsp.next_interval_compare = state_next.interval_compare;
      rsp.next_poll_compare     = state_next.poll_compare;
   end

endmodule

/* src/capture_timestamp_extender.sv */
// Top level: timer capture timestamp extender with request register and skid result buffer.
// An accepted request is registered; its result goes to the result register or the skid stage.
// Throughput: one request per cycle while req_stall is low; the event logic between the request
// register and the result register is a single pass, and a one-entry skid stage absorbs rsp_stall.
// Reset: synchronous, active high; clears all state to zero, registers to their defaults.
// req_stall comes from registers only; it rises while the request register and both slots are full.
module capture_timestamp_extender #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_overflow_flag,
   input  logic        req_capture_a_flag,
   input  logic        req_capture_b_flag,
   input  logic        req_interval_flag,
   input  logic        req_poll_flag,
   input  logic [15:0] req_capture_a_value,
   input  logic [15:0] req_capture_b_value,
   input  logic [31:0] req_encoder_count_a,
   input  logic [31:0] req_encoder_count_b,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_time_a,
   output logic [31:0] rsp_position_a,
   output logic [31:0] rsp_captures_a,
   output logic [63:0] rsp_time_b,
   output logic [31:0] rsp_position_b,
   output logic [31:0] rsp_captures_b,
   output logic [31:0] rsp_frame_count,
   output logic [31:0] rsp_poll_count,
   output logic        rsp_frame_end,
   output logic [15:0] rsp_next_interval_compare,
   output logic [15:0] rsp_next_poll_compare,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int EXT_W = 64 - COUNTER_WIDTH;

   cte_pkg::cfg_type   cfg_ff, cfg_in;
   cte_pkg::state_type state_ff, state_in;
   logic [EXT_W-1:0]   ext_ff, ext_in;

   cte_pkg::req_type   req_ff, req_in;
   logic               req_valid_ff, req_valid_in;

   cte_pkg::rsp_type   out_ff, out_in;
   logic               out_valid_ff, out_valid_in;
   cte_pkg::rsp_type   skid_ff, skid_in;
   logic               skid_valid_ff, skid_valid_in;

   cte_pkg::rsp_type   rsp_calc;
   logic               req_take;
   logic               fire;
   logic               out_take;
   logic               cfg_write;
   logic [1:0]         cfg_index;

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            cte_pkg::REG_INTERVAL_STEP:       cfg_in.interval_step = csr_pwdata[15:0];
            cte_pkg::REG_POLL_STEP:           cfg_in.poll_step = csr_pwdata[15:0];
            cte_pkg::REG_INTERVALS_PER_FRAME: cfg_in.intervals_per_frame = csr_pwdata[7:0];
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         cte_pkg::REG_INTERVAL_STEP:       csr_prdata = {16'd0, cfg_ff.interval_step};
         cte_pkg::REG_POLL_STEP:           csr_prdata = {16'd0, cfg_ff.poll_step};
         cte_pkg::REG_INTERVALS_PER_FRAME: csr_prdata = {24'd0, cfg_ff.intervals_per_frame};
         default:                          csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Request register and handshake
   // ------------------------------------------------------------------
   assign req_stall = req_valid_ff && skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign fire      = req_valid_ff && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   always_comb begin
      req_in.overflow_flag   = req_overflow_flag;
      req_in.capture_a_flag  = req_capture_a_flag;
      req_in.capture_b_flag  = req_capture_b_flag;
      req_in.interval_flag   = req_interval_flag;
      req_in.poll_flag       = req_poll_flag;
      req_in.capture_a_value = req_capture_a_value;
      req_in.capture_b_value = req_capture_b_value;
      req_in.encoder_count_a = req_encoder_count_a;
      req_in.encoder_count_b = req_encoder_count_b;
      if (!req_take) begin
         req_in = req_ff;
      end
      req_valid_in = req_take || (req_valid_ff && !fire);
   end

   cte_event_logic #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_event_logic (
      .req        (req_ff),
      .state      (state_ff),
      .ext        (ext_ff),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .ext_next   (ext_in),
      .rsp        (rsp_calc)
   );

   // ------------------------------------------------------------------
   // Result register with skid stage
   // ------------------------------------------------------------------
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = rsp_calc;
            out_valid_in = fire;
         end
      end else if (fire) begin
         // result slot still waiting: park the new result
         skid_in       = rsp_calc;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_step       <= cte_pkg::INTERVAL_STEP_RESET;
         cfg_ff.poll_step           <= cte_pkg::POLL_STEP_RESET;
         cfg_ff.intervals_per_frame <= cte_pkg::INTERVALS_PER_FRAME_RESET;
         state_ff                   <= '0;
         ext_ff                     <= '0;
         req_valid_ff               <= 1'b0;
         out_valid_ff               <= 1'b0;
         skid_valid_ff              <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         req_valid_ff  <= req_valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (fire) begin
            state_ff <= state_in;
            ext_ff   <= ext_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid                 = out_valid_ff;
   assign rsp_time_a                = out_ff.time_a;
   assign rsp_position_a            = out_ff.position_a;
   assign rsp_captures_a            = out_ff.captures_a;
   assign rsp_time_b                = out_ff.time_b;
   assign rsp_position_b            = out_ff.position_b;
   assign rsp_captures_b            = out_ff.captures_b;
   assign rsp_frame_count           = out_ff.frame_count;
   assign rsp_poll_count            = out_ff.poll_count;
   assign rsp_frame_end             = out_ff.frame_end;
   assign rsp_next_interval_compare = out_ff.next_interval_compare;
   assign rsp_next_poll_compare     = out_ff.next_poll_compare;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the result slot is empty");

   a_stall_needs_request: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff)
      else $error("request stalled with no request in flight");

   a_frame_clears_count: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp_calc.frame_end) |=> (state_ff.interval_count == 8'd0))
      else $error("interval count not cleared at frame end");

   a_overflow_advances: assert property (@(posedge clock) disable iff (reset)
      (fire && req_ff.overflow_flag) |=> (ext_ff == $past(ext_ff) + EXT_W'(1)))
      else $error("extension did not advance on overflow");
`endif

endmodule

/* tb/tb_capture_timestamp_extender.sv */
// Self-checking testbench for the capture timestamp extender: directed and random timer events.
module tb_capture_timestamp_extender;

   localparam logic [1:0] REG_UNMAPPED = 2'd3;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_stall;
   cte_pkg::req_type req_event = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_time_a;
   logic [31:0] rsp_position_a;
   logic [31:0] rsp_captures_a;
   logic [63:0] rsp_time_b;
   logic [31:0] rsp_position_b;
   logic [31:0] rsp_captures_b;
   logic [31:0] rsp_frame_count;
   logic [31:0] rsp_poll_count;
   logic        rsp_frame_end;
   logic [15:0] rsp_next_interval_compare;
   logic [15:0] rsp_next_poll_compare;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor copy of the block's registers and state
   cte_pkg::cfg_type   cfg_shadow;
   cte_pkg::state_type track;
   logic [47:0]        wrap_count;
   cte_pkg::rsp_type   pending_snapshots[$];

   int errors = 0;
   int cycles = 0;
   int gap_pct = 20;
   int stall_pct = 20;
   int overflow_pct = 25;
   int interval_pct = 50;
   int stall_left = 0;
   int stall_len;
   bit holdoff_request = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   capture_timestamp_extender u_top (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_overflow_flag         (req_event.overflow_flag),
      .req_capture_a_flag        (req_event.capture_a_flag),
      .req_capture_b_flag        (req_event.capture_b_flag),
      .req_interval_flag         (req_event.interval_flag),
      .req_poll_flag             (req_event.poll_flag),
      .req_capture_a_value       (req_event.capture_a_value),
      .req_capture_b_value       (req_event.capture_b_value),
      .req_encoder_count_a       (req_event.encoder_count_a),
      .req_encoder_count_b       (req_event.encoder_count_b),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_time_a                (rsp_time_a),
      .rsp_position_a            (rsp_position_a),
      .rsp_captures_a            (rsp_captures_a),
      .rsp_time_b                (rsp_time_b),
      .rsp_position_b            (rsp_position_b),
      .rsp_captures_b            (rsp_captures_b),
      .rsp_frame_count           (rsp_frame_count),
      .rsp_poll_count            (rsp_poll_count),
      .rsp_frame_end             (rsp_frame_end),
      .rsp_next_interval_compare (rsp_next_interval_compare),
      .rsp_next_poll_compare     (rsp_next_poll_compare),
      .csr_psel                  (csr_psel),
      .csr_penable               (csr_penable),
      .csr_pwrite                (csr_pwrite),
      .csr_paddr                 (csr_paddr),
      .csr_pwdata                (csr_pwdata),
      .csr_prdata                (csr_prdata),
      .csr_pready                (csr_pready)
   );

   function automatic logic [63:0] extend_capture(logic [15:0] value, logic wrapped);
      logic [63:0] stamp;
      stamp = {wrap_count, value};
      // an upper-half value seen with a wrap was latched before the wrap
      if (wrapped && value > 16'h7FFF) stamp = stamp - 64'h1_0000;
      return stamp;
   endfunction

   function automatic cte_pkg::rsp_type advance_timer_state(cte_pkg::req_type ev);
      cte_pkg::rsp_type snap;
      snap = '0;
      if (ev.poll_flag) begin
         track.poll_compare = track.poll_compare + cfg_shadow.poll_step;
         track.poll_ticks = track.poll_ticks + 1;
      end
      if (ev.overflow_flag) wrap_count = wrap_count + 1;
      if (ev.capture_a_flag) begin
         track.time_a = extend_capture(ev.capture_a_value, ev.overflow_flag);
         track.position_a = ev.encoder_count_a;
         track.captures_a = track.captures_a + 1;
      end
      if (ev.capture_b_flag) begin
         track.time_b = extend_capture(ev.capture_b_value, ev.overflow_flag);
         track.position_b = ev.encoder_count_b;
         track.captures_b = track.captures_b + 1;
      end
      if (ev.interval_flag) begin
         track.interval_compare = track.interval_compare + cfg_shadow.interval_step;
         track.interval_count = track.interval_count + 1;
         if (track.interval_count >= cfg_shadow.intervals_per_frame) begin
            track.interval_count = '0;
            track.frame_ticks = track.frame_ticks + 1;
            snap.frame_end = 1'b1;
         end
      end
      snap.time_a = track.time_a;
      snap.position_a = track.position_a;
      snap.captures_a = track.captures_a;
      snap.time_b = track.time_b;
      snap.position_b = track.position_b;
      snap.captures_b = track.captures_b;
      snap.frame_count = track.frame_ticks;
      snap.poll_count = track.poll_ticks;
      snap.next_interval_compare = track.interval_compare;
      snap.next_poll_compare = track.poll_compare;
      return snap;
   endfunction

   task automatic check_field(input string name, input logic [63:0] expected,
                              input logic [63:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, expected, actual);
         errors++;
      end
   endtask

   // predict on every accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_snapshots.push_back(advance_timer_state(req_event));
   end

   always @(posedge clock) begin
      cte_pkg::rsp_type snap;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_snapshots.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual time_a %0h",
                     $time, rsp_time_a);
            errors++;
         end else begin
            snap = pending_snapshots.pop_front();
            check_field("time_a", snap.time_a, rsp_time_a);
            check_field("position_a", snap.position_a, rsp_position_a);
            check_field("captures_a", snap.captures_a, rsp_captures_a);
            check_field("time_b", snap.time_b, rsp_time_b);
            check_field("position_b", snap.position_b, rsp_position_b);
            check_field("captures_b", snap.captures_b, rsp_captures_b);
            check_field("frame_count", snap.frame_count, rsp_frame_count);
            check_field("poll_count", snap.poll_count, rsp_poll_count);
            check_field("frame_end", snap.frame_end, rsp_frame_end);
            check_field("next_interval_compare", snap.next_interval_compare,
                        rsp_next_interval_compare);
            check_field("next_poll_compare", snap.next_poll_compare, rsp_next_poll_compare);
         end
      end
   end

   function automatic int pick_gap(int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(30, 8);
      return $urandom_range(3, 1);
   endfunction

   // result side stall: random gaps, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (holdoff_request) begin
         holdoff_request = 1'b0;
         rsp_stall <= 1'b1;
         stall_left <= HOLDOFF_CYCLES;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         stall_len = pick_gap(stall_pct);
         rsp_stall <= (stall_len != 0);
         stall_left <= (stall_len != 0) ? stall_len - 1 : 0;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("capture_timestamp_extender test failed");
         $finish;
      end
   end

   function automatic logic [15:0] random_capture_value();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'hFFFF;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic cte_pkg::req_type random_event();
      cte_pkg::req_type ev;
      ev.overflow_flag = ($urandom_range(99) < overflow_pct);
      ev.capture_a_flag = 1'($urandom_range(1));
      ev.capture_b_flag = 1'($urandom_range(1));
      ev.interval_flag = ($urandom_range(99) < interval_pct);
      ev.poll_flag = 1'($urandom_range(1));
      ev.capture_a_value = random_capture_value();
      ev.capture_b_value = random_capture_value();
      ev.encoder_count_a = $urandom();
      ev.encoder_count_b = $urandom();
      return ev;
   endfunction

   function automatic cte_pkg::req_type make_event(logic ov, logic cap_a, logic cap_b,
                                                   logic ivl, logic pol,
                                                   logic [15:0] value_a,
                                                   logic [15:0] value_b,
                                                   logic [31:0] enc_a,
                                                   logic [31:0] enc_b);
      cte_pkg::req_type ev;
      ev.overflow_flag = ov;
      ev.capture_a_flag = cap_a;
      ev.capture_b_flag = cap_b;
      ev.interval_flag = ivl;
      ev.poll_flag = pol;
      ev.capture_a_value = value_a;
      ev.capture_b_value = value_b;
      ev.encoder_count_a = enc_a;
      ev.encoder_count_b = enc_b;
      return ev;
   endfunction

   // hold the request until accepted, then idle for a random gap
   task automatic send_event(input cte_pkg::req_type ev);
      int gap;
      req_valid <= 1'b1;
      req_event <= ev;
      do @(posedge clock); while (req_stall);
      gap = pick_gap(gap_pct);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_snapshots.size() != 0);
   endtask

   // setup then access phase; psel stays high so transfers can run back to back
   task automatic csr_transfer(input logic write, input logic [1:0] index,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {index, 2'b00};
      if (write) csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (write) begin
         case (index)
            cte_pkg::REG_INTERVAL_STEP:       cfg_shadow.interval_step = wdata[15:0];
            cte_pkg::REG_POLL_STEP:           cfg_shadow.poll_step = wdata[15:0];
            cte_pkg::REG_INTERVALS_PER_FRAME: cfg_shadow.intervals_per_frame = wdata[7:0];
            default: ;
         endcase
      end
   endtask

   task automatic csr_release();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_registers();
      logic [31:0] value;
      csr_transfer(1'b0, cte_pkg::REG_INTERVAL_STEP, '0, value);
      check_field("interval_step", cfg_shadow.interval_step, value);
      csr_transfer(1'b0, cte_pkg::REG_POLL_STEP, '0, value);
      check_field("poll_step", cfg_shadow.poll_step, value);
      csr_transfer(1'b0, cte_pkg::REG_INTERVALS_PER_FRAME, '0, value);
      check_field("intervals_per_frame", cfg_shadow.intervals_per_frame, value);
   endtask

   // write all registers with junk in the unused upper bits, then read back
   task automatic configure(input logic [15:0] istep, input logic [15:0] pstep,
                            input logic [7:0] frame_len);
      logic [31:0] noise;
      logic [31:0] unused;
      drain_results();
      noise = $urandom();
      csr_transfer(1'b1, cte_pkg::REG_INTERVAL_STEP, {noise[31:16], istep}, unused);
      noise = $urandom();
      csr_transfer(1'b1, cte_pkg::REG_POLL_STEP, {noise[31:16], pstep}, unused);
      noise = $urandom();
      csr_transfer(1'b1, cte_pkg::REG_INTERVALS_PER_FRAME, {noise[31:8], frame_len}, unused);
      check_registers();
      csr_release();
   endtask

   task automatic send_intervals(input int count);
      repeat (count) send_event(make_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0, 16'h0,
                                           32'h0, 32'h0));
   endtask

   task automatic run_random_events(input int count, input int gaps, input int stalls);
      gap_pct = gaps;
      stall_pct = stalls;
      repeat (count) send_event(random_event());
   endtask

   task automatic test_register_access();
      logic [31:0] unused;
      check_registers();
      // an unmapped index must leave every register alone
      csr_transfer(1'b1, REG_UNMAPPED, $urandom(), unused);
      check_registers();
      csr_release();
   endtask

   task automatic test_capture_events();
      gap_pct = 20;
      stall_pct = 20;
      send_event(make_event(0, 0, 0, 0, 0, 16'h0000, 16'h0000, 32'h0, 32'h0));
      send_event(make_event(0, 1, 0, 0, 0, 16'h1234, 16'h0000, 32'h1111_2222, 32'h0));
      send_event(make_event(0, 0, 1, 0, 0, 16'h0000, 16'hFFFF, 32'h0, 32'hFFFF_FFFF));
      send_event(make_event(1, 0, 0, 0, 0, 16'h0000, 16'h0000, 32'h0, 32'h0));
      // half-range boundary: A keeps its time, B is set back one wrap
      send_event(make_event(1, 1, 1, 0, 0, 16'h7FFF, 16'h8000, 32'hA5A5_A5A5,
                            32'h5A5A_5A5A));
      send_event(make_event(1, 1, 1, 0, 0, 16'hFFFF, 16'h0000, 32'h0000_0001,
                            32'h8000_0000));
      send_event(make_event(0, 0, 0, 1, 0, 16'h0000, 16'h0000, 32'h0, 32'h0));
      send_event(make_event(0, 0, 0, 0, 1, 16'h0000, 16'h0000, 32'h0, 32'h0));
      send_event(make_event(1, 1, 1, 1, 1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
      send_event(make_event(1, 1, 1, 1, 1, 16'h0000, 16'h0000, 32'h0, 32'h0));
   endtask

   task automatic test_frame_length();
      configure(cfg_shadow.interval_step, cfg_shadow.poll_step, 8'd2);
      send_intervals(4);
      // zero frame length ends a frame on every match
      configure(cfg_shadow.interval_step, cfg_shadow.poll_step, 8'd0);
      send_intervals(2);
      configure(cfg_shadow.interval_step, cfg_shadow.poll_step, 8'd6);
      send_intervals(4);
      // lower the frame length below the running count
      configure(cfg_shadow.interval_step, cfg_shadow.poll_step, 8'd2);
      send_intervals(1);
      configure(cfg_shadow.interval_step, cfg_shadow.poll_step, 8'd1);
      send_intervals(1);
   endtask

   task automatic test_compare_steps();
      configure(16'h0000, 16'h0000, 8'd1);
      send_event(make_event(0, 0, 0, 1, 1, 16'h0000, 16'h0000, 32'h0, 32'h0));
      send_event(make_event(0, 0, 0, 1, 1, 16'h0000, 16'h0000, 32'h0, 32'h0));
      configure(16'hFFFF, 16'hFFFF, 8'd255);
      send_event(make_event(0, 0, 0, 1, 1, 16'h0000, 16'h0000, 32'h0, 32'h0));
      send_event(make_event(0, 0, 0, 1, 1, 16'h0000, 16'h0000, 32'h0, 32'h0));
   endtask

   task automatic test_backpressure();
      drain_results();
      stall_pct = 0;
      gap_pct = 0;
      holdoff_request = 1'b1;
      // keep offering requests so the block fills up and stalls its input
      repeat (40) send_event(random_event());
      drain_results();
   endtask

   task automatic test_random_traffic();
      configure(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                8'($urandom_range(40, 1)));
      run_random_events(300, 30, 30);
      configure(16'hFFFF, 16'hFFFF, 8'd1);
      run_random_events(200, 0, 0);
      // mostly interval matches so the longest frame still completes
      configure(16'h0000, 16'h0000, 8'd255);
      interval_pct = 90;
      run_random_events(400, 20, 50);
      interval_pct = 50;
      configure(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)), 8'd0);
      overflow_pct = 60;
      run_random_events(300, 60, 60);
      overflow_pct = 25;
      configure(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                8'($urandom_range(255, 1)));
      run_random_events(200, 10, 10);
   endtask

   initial begin
      cfg_shadow.interval_step = cte_pkg::INTERVAL_STEP_RESET;
      cfg_shadow.poll_step = cte_pkg::POLL_STEP_RESET;
      cfg_shadow.intervals_per_frame = cte_pkg::INTERVALS_PER_FRAME_RESET;
      track = '0;
      wrap_count = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_capture_events();
      test_frame_length();
      test_compare_steps();
      test_backpressure();
      test_random_traffic();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("capture_timestamp_extender test passed");
      end else begin
         $display("capture_timestamp_extender test failed");
      end
      $finish;
   end

endmodule

/* capture_timestamp_extender.f */
src/cte_pkg.sv
src/cte_event_logic.sv
src/capture_timestamp_extender.sv
tb/tb_capture_timestamp_extender.sv
